### hw/rtl/q8_block_weight_dequantizer_unit_assert.svh
// Assertion macros for the dequantizer
`ifndef Q8_BLOCK_WEIGHT_DEQUANTIZER_UNIT_ASSERT_SVH
`define Q8_BLOCK_WEIGHT_DEQUANTIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define Q8D_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define Q8D_ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define Q8D_ASSERT(label, clk, rstn, prop, msg)
`define Q8D_ASSERT_RST(label, clk, rstn, prop, msg)
`endif
`endif

### hw/rtl/q8d_pkg.sv
package q8d_pkg;
  localparam int unsigned BlockValues = 32;
  localparam int unsigned PosW = $clog2(BlockValues + 2);
  localparam int unsigned IdxW = 5;

  typedef enum logic {
    ELEM_F32 = 1'b0,
    ELEM_Q80 = 1'b1
  } elem_type_e;

  typedef enum logic {
    FMT_F32  = 1'b0,
    FMT_BF16 = 1'b1
  } out_fmt_e;

  localparam logic CfgElementType  = 1'b0;
  localparam logic CfgOutputFormat = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       tensor_start;
  } in_item_t;

  typedef struct packed {
    logic [31:0]     value_bits;
    logic [IdxW-1:0] element_index;
    logic            block_last;
  } out_item_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] s;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [9:0]  m;
    logic [7:0]  e;
    logic        found;
    s   = {h[15], 31'd0};
    ex  = h[14:10];
    man = h[9:0];
    m   = '0;
    e   = '0;
    found = 1'b0;
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        return s;
      end
      for (int i = 9; i >= 0; i--) begin
        if (!found && man[i]) begin
          found = 1'b1;
          e = 8'(103 + i);
          m = 10'(man << (10 - i));
        end
      end
      return s | {1'b0, e, m, 13'd0};
    end
    if (ex == 5'd31) begin
      return s | 32'h7F80_0000 | {9'd0, man, 13'd0};
    end
    return s | {1'b0, 8'({3'd0, ex} + 8'd112), man, 13'd0};
  endfunction

  function automatic logic [31:0] format_value(input logic [31:0] b, input logic bf);
    logic [31:0] r;
    r = b + 32'h7FFF + {31'd0, b[16]};
    if (!bf) begin
      return b;
    end
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
      return {16'd0, b[31:16] | 16'h0040};
    end
    return {16'd0, r[31:16]};
  endfunction
endpackage

### hw/rtl/q8d_stream_if.sv
interface q8d_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/q8d_scale_mul.sv
module q8d_scale_mul (
  input  logic [31:0] scale_i,
  input  logic [7:0]  q_i,
  output logic [31:0] prod_o
);
  import q8d_pkg::*;
  logic        sgn;
  logic [7:0]  mag;
  logic [7:0]  ex;
  logic [23:0] sig;
  logic [31:0] p;
  logic [4:0]  lz;
  logic        fnd;
  logic [31:0] pn;
  logic signed [10:0] e_r;
  logic [10:0] shamt;
  logic [31:0] ps;
  always_comb begin
    sgn = scale_i[31] ^ q_i[7];
    mag = q_i[7] ? 8'(-q_i) : q_i;
    ex  = scale_i[30:23];
    sig = (ex == 8'd0) ? {1'b0, scale_i[22:0]} : {1'b1, scale_i[22:0]};
    p   = {24'd0, mag} * {8'd0, sig};
    lz  = '0;
    fnd = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!fnd && p[i]) begin
        fnd = 1'b1;
        lz  = 5'(31 - i);
      end
    end
    pn = p << lz;
    e_r = 11'(signed'({3'd0, ex})) + ((ex == 8'd0) ? 11'sd1 : 11'sd0) + 11'sd8 - 11'(lz);
    shamt = '0;
    ps = pn;
    if (e_r <= 0) begin
      shamt = 11'(11'sd1 - e_r);
      ps = (shamt > 11'd31) ? 32'd0 : pn >> shamt[4:0];
      prod_o = {sgn, 8'd0, ps[31:9]};
    end else begin
      prod_o = {sgn, e_r[7:0], pn[30:8]};
    end
    if (!fnd) begin
      prod_o = {sgn, 31'd0};
    end
    if (ex == 8'hFF) begin
      if (scale_i[22:0] != 23'd0) begin
        prod_o = scale_i | 32'h0040_0000;
      end else if (q_i == 8'd0) begin
        prod_o = 32'h7FC0_0000;
      end else begin
        prod_o = {sgn, 31'h7F80_0000};
      end
    end
  end
endmodule

### hw/rtl/q8_block_weight_dequantizer_unit.sv
// channel | dir | payload
// in_if   | in  | data_byte[7:0], tensor_start
// out_if  | out | value_bits[31:0], element_index[4:0], block_last
// cfg     | in  | cfg_we_i, cfg_index_i, cfg_wdata_i
// One item is accepted per cycle while input is not stalled; its result is registered.
// The single output register stalls input only when full and not taken.
// Reset clears position, scale, gather, valid; element_type=Q8_0, output_format=fp32.
// Input bytes producing no result (scale, partial word) are still accepted through the same handshake.
`include "q8_block_weight_dequantizer_unit_assert.svh"
module q8_block_weight_dequantizer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_index_i,
  input  logic cfg_wdata_i,
  q8d_stream_if.sink   in_if,
  q8d_stream_if.source out_if
);
  import q8d_pkg::*;
  logic [PosW-1:0] pos_q, pos_d, pos;
  logic [15:0] scale_q, scale_d;
  logic [23:0] gath_q, gath_d;
  elem_type_e etype_q;
  out_fmt_e   ofmt_q;
  logic       ov_q;
  out_item_t  oi_q, oi_d;
  logic       fire, emit;
  logic [31:0] prod;
  logic [7:0]  b;
  localparam logic [PosW-1:0] LastPos = PosW'(BlockValues + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BlockValues - 1);

  assign in_if.ready = !ov_q || out_if.ready;
  assign fire = in_if.valid && in_if.ready;
  assign b = in_if.data.data_byte;

  q8d_scale_mul u_mul (.scale_i(half_to_single(scale_q)), .q_i(b), .prod_o(prod));

  always_comb begin
    pos    = in_if.data.tensor_start ? '0 : pos_q;
    pos_d  = pos_q;
    scale_d = scale_q;
    gath_d = gath_q;
    emit   = 1'b0;
    oi_d   = oi_q;
    if (etype_q == ELEM_F32) begin
      if (pos >= PosW'(3)) begin
        emit  = 1'b1;
        pos_d = '0;
        oi_d.value_bits = format_value({b, gath_q}, ofmt_q == FMT_BF16);
        oi_d.element_index = '0;
        oi_d.block_last = 1'b1;
      end else begin
        unique case (pos[1:0])
          2'd0: gath_d[7:0] = b;
          2'd1: gath_d[15:8] = b;
          default: gath_d[23:16] = b;
        endcase
        pos_d = pos + PosW'(1);
      end
    end else if (pos == '0) begin
      scale_d[7:0] = b;
      pos_d = PosW'(1);
    end else if (pos == PosW'(1)) begin
      scale_d[15:8] = b;
      pos_d = PosW'(2);
    end else begin
      emit = 1'b1;
      oi_d.value_bits = format_value(prod, ofmt_q == FMT_BF16);
      oi_d.block_last = pos >= LastPos;
      oi_d.element_index = (pos >= LastPos) ? LastIdx : IdxW'(pos - PosW'(2));
      pos_d = (pos >= LastPos) ? '0 : pos + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      scale_q <= '0;
      gath_q <= '0;
      etype_q <= ELEM_Q80;
      ofmt_q <= FMT_F32;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgElementType) etype_q <= elem_type_e'(cfg_wdata_i);
      if (cfg_we_i && cfg_index_i == CfgOutputFormat) ofmt_q <= out_fmt_e'(cfg_wdata_i);
      if (fire) begin
        pos_q <= pos_d;
        scale_q <= scale_d;
        gath_q <= gath_d;
        ov_q <= emit;
      end else if (out_if.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) oi_q <= oi_d;
  end

  assign out_if.valid = ov_q;
  assign out_if.data  = oi_q;

  `Q8D_ASSERT(a_stall_hold, clk_i, rst_ni, (ov_q && !out_if.ready) |=> ov_q && $stable(oi_q), "item lost")
  `Q8D_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= LastPos, "position out of range")
  `Q8D_ASSERT(a_idx_last, clk_i, rst_ni, (ov_q && !oi_q.block_last) |-> oi_q.element_index != LastIdx, "bad index")
  `Q8D_ASSERT_RST(a_rst_idle, clk_i, rst_ni, !rst_ni |-> !ov_q, "valid in reset")
endmodule
